/* src/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the character classifier of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int SEXTET_W    = 6;
   localparam int ACC_W       = 3 * SEXTET_W;
   localparam int QUARTET_W   = 4 * SEXTET_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

   typedef enum logic [1:0] {
      CLS_DATA,
      CLS_PAD,
      CLS_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type         kind;
      logic [SEXTET_W-1:0]   sextet;
   } char_class_type;

   // one decoded quartet or an error marker, front to back
   typedef struct packed {
      logic [QUARTET_W-1:0]  bits;
      logic [1:0]            nbytes;
      logic                  last;
      logic                  err;
   } job_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type r;
      logic [CHAR_W-1:0] t;
      r.kind   = CLS_DATA;
      r.sextet = '0;
      t        = '0;
      if (c inside {[CHAR_UA:CHAR_UZ]}) begin
         t = c - CHAR_UA;
      end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
         t = c - CHAR_LA + 8'd26;
      end else if (c inside {[CHAR_D0:CHAR_D9]}) begin
         t = c - CHAR_D0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         t = 8'd62;
      end else if (c == CHAR_SLASH) begin
         t = 8'd63;
      end else if (c == CHAR_PAD) begin
         r.kind = CLS_PAD;
      end else begin
         r.kind = CLS_BAD;
      end
      r.sextet = t[SEXTET_W-1:0];
      return r;
   endfunction

endpackage

/* src/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// classifies characters, gathers quartets and checks padding and length
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [b64d_pkg::CHAR_W-1:0]  character,
   input  logic                         last_char,
   output logic                         push,
   output b64d_pkg::job_type            job
);
   import b64d_pkg::*;

   logic [ACC_W-1:0]    acc_ff,  acc_in;
   logic [1:0]          pos_ff,  pos_in;
   logic [1:0]          pad_ff,  pad_in;
   logic                err_ff,  err_in;

   char_class_type      cls;
   logic [1:0]          pad_n;
   logic                err_n;

   always_comb begin
      cls   = classify(character);
      pad_n = pad_ff;
      err_n = err_ff;
      case (cls.kind)
         CLS_BAD: begin
            err_n = 1'b1;
         end
         CLS_PAD: begin
            if (pos_ff < 2'd2) begin
               err_n = 1'b1;
            end else begin
               pad_n = pad_ff + 2'd1;
            end
         end
         default: begin
            if (pad_ff != 2'd0) begin
               err_n = 1'b1;
            end
         end
      endcase
      if (pos_ff == 2'd3 && pad_n != 2'd0 && !last_char) begin
         err_n = 1'b1;
      end

      job.bits   = {acc_ff, cls.sextet};
      job.nbytes = 2'd3 - pad_n;
      job.last   = last_char;
      job.err    = last_char && (err_n || pos_ff != 2'd3);
      push       = accept && ((pos_ff == 2'd3 && !err_n) || last_char);

      acc_in = acc_ff;
      pos_in = pos_ff;
      pad_in = pad_ff;
      err_in = err_ff;
      if (accept) begin
         if (last_char || pos_ff == 2'd3) begin
            acc_in = '0;
            pos_in = '0;
            pad_in = '0;
            err_in = last_char ? 1'b0 : err_n;
         end else begin
            acc_in = {acc_ff[ACC_W-SEXTET_W-1:0], cls.sextet};
            pos_in = pos_ff + 2'd1;
            pad_in = pad_n;
            err_in = err_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= '0;
         pad_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

endmodule

/* src/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64d_pkg::job_type    push_job,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output b64d_pkg::job_type    head_job
);
   import b64d_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in;
   logic [QPTR_W-1:0]    rd_ff, rd_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      head_valid = (cnt_ff != '0);
      head_job   = slot_ff[rd_ff];
      wr_in      = push ? QPTR_W'((QPTR_W+1)'(wr_ff) + 1'b1) : wr_ff;
      rd_in      = pop  ? QPTR_W'((QPTR_W+1)'(rd_ff) + 1'b1) : rd_ff;
      cnt_in     = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// splits queued quartets into bytes and holds the output register
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  b64d_pkg::job_type             head_job,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [b64d_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import b64d_pkg::*;

   logic [1:0]          idx_ff, idx_in;
   logic                vld_ff, vld_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;

   logic                load;
   logic                final_byte;
   logic [BYTE_W-1:0]   sel_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_job.bits[3*BYTE_W-1:2*BYTE_W];
         2'd1:    sel_byte = head_job.bits[2*BYTE_W-1:BYTE_W];
         default: sel_byte = head_job.bits[BYTE_W-1:0];
      endcase
      final_byte = head_job.err || (idx_ff + 2'd1 == head_job.nbytes);
      load       = head_valid && (!vld_ff || rsp_tready);
      pop        = load && final_byte;

      idx_in  = idx_ff;
      vld_in  = vld_ff && !rsp_tready;
      data_in = data_ff;
      last_in = last_ff;
      err_in  = err_ff;
      if (load) begin
         vld_in  = 1'b1;
         data_in = head_job.err ? '0 : sel_byte;
         last_in = head_job.last && final_byte;
         err_in  = head_job.err;
         idx_in  = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule

/* src/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character in and up to three bytes out
// ----------------------------------------------------------------------------
// takes one base64 character per cycle while the queue is not full and, for
// every complete quartet, gives one to three bytes at one byte per cycle
// while rsp_tready is high, the final byte of the message marked by tlast. a
// bad character, misplaced padding or a length that is not a multiple of four
// ends the message in one error result (tuser high, data zero) at its last
// character. the front part checks and gathers characters, handing each
// quartet to a four-entry queue; the back part drains it a byte per cycle
// into the output register, so input runs at one character per cycle while
// the output side keeps up; a byte passes the queue, then the output register.
module base64_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [b64d_pkg::CHAR_W-1:0]   req_tdata,   // character
   input  logic                          req_tlast,   // last_char
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [b64d_pkg::BYTE_W-1:0]   rsp_tdata,   // data_byte
   output logic                          rsp_tlast,   // last_byte
   output logic                          rsp_tuser    // error
);
   import b64d_pkg::*;

   logic       accept;
   logic       push;
   logic       pop;
   logic       full;
   logic       head_valid;
   job_type    push_job;
   job_type    head_job;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .character (req_tdata),
      .last_char (req_tlast),
      .push      (push),
      .job       (push_job)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* test/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// watches both streams of the base64 decoder, predicts every decoded byte and
// error result from the accepted requests and compares them in order
// ----------------------------------------------------------------------------
module b64d_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [b64d_pkg::CHAR_W-1:0]   req_tdata,   // character
   input  logic                          req_tlast,   // last_char
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [b64d_pkg::BYTE_W-1:0]   rsp_tdata,   // data_byte
   input  logic                          rsp_tlast,   // last_byte
   input  logic                          rsp_tuser,   // error
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               last;
      logic               err;
   } byte_result_type;

   byte_result_type        expected_bytes[$];
   char_kind_type          kind_of [0:255];
   logic [SEXTET_W-1:0]    sextet_of [0:255];
   logic [ACC_W-1:0]       sextet_acc;
   logic [1:0]             quartet_pos;
   logic [1:0]             pad_count;
   logic                   msg_bad;
   int                     fault_total = 0;

   initial begin
      int c;
      for (c = 0; c < 256; c++) begin
         kind_of[c]   = CLS_BAD;
         sextet_of[c] = '0;
      end
      for (c = 0; c < 26; c++) begin
         kind_of[CHAR_UA + c]   = CLS_DATA;
         sextet_of[CHAR_UA + c] = SEXTET_W'(c);
         kind_of[CHAR_LA + c]   = CLS_DATA;
         sextet_of[CHAR_LA + c] = SEXTET_W'(c + 26);
      end
      for (c = 0; c < 10; c++) begin
         kind_of[CHAR_D0 + c]   = CLS_DATA;
         sextet_of[CHAR_D0 + c] = SEXTET_W'(c + 52);
      end
      kind_of[CHAR_PLUS]    = CLS_DATA;
      sextet_of[CHAR_PLUS]  = 6'd62;
      kind_of[CHAR_SLASH]   = CLS_DATA;
      sextet_of[CHAR_SLASH] = 6'd63;
      kind_of[CHAR_PAD]     = CLS_PAD;
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      fault_total++;
   endtask

   task automatic clear_message();
      sextet_acc  = '0;
      quartet_pos = '0;
      pad_count   = '0;
      msg_bad     = 1'b0;
   endtask

   task automatic decode_char(input logic [CHAR_W-1:0] ch, input logic fin);
      logic [1:0]            pos;
      logic [SEXTET_W-1:0]   sx;
      logic [QUARTET_W-1:0]  quartet;
      int                    nbytes;
      int                    k;
      byte_result_type       r;
      pos = quartet_pos;
      sx  = '0;
      case (kind_of[ch])
         CLS_BAD: msg_bad = 1'b1;
         CLS_PAD: begin
            if (pos < 2'd2) msg_bad = 1'b1;
            else pad_count = pad_count + 2'd1;
         end
         default: begin
            if (pad_count != 2'd0) msg_bad = 1'b1;
            sx = sextet_of[ch];
         end
      endcase
      if (pos != 2'd3) begin
         sextet_acc  = {sextet_acc[ACC_W-SEXTET_W-1:0], sx};
         quartet_pos = pos + 2'd1;
      end else begin
         quartet = {sextet_acc, sx};
         nbytes  = 3 - pad_count;
         // padding is only legal in the closing quartet
         if (pad_count != 2'd0 && !fin) msg_bad = 1'b1;
         if (!msg_bad) begin
            for (k = 0; k < nbytes; k++) begin
               r.data = quartet[QUARTET_W-1-8*k -: 8];
               r.last = fin && (k == nbytes - 1);
               r.err  = 1'b0;
               expected_bytes.push_back(r);
            end
         end
         sextet_acc  = '0;
         quartet_pos = '0;
         pad_count   = '0;
      end
      if (fin) begin
         if (msg_bad || pos != 2'd3) begin
            r.data = '0;
            r.last = 1'b1;
            r.err  = 1'b1;
            expected_bytes.push_back(r);
         end
         clear_message();
      end
   endtask

   always @(posedge clock) begin
      byte_result_type want;
      if (reset) begin
         expected_bytes.delete();
         clear_message();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected result, rsp_tdata", int'(rsp_tdata), 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch("rsp_tdata", int'(rsp_tdata), int'(want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch("rsp_tlast", int'(rsp_tlast), int'(want.last));
               if (rsp_tuser !== want.err)
                  report_mismatch("rsp_tuser", int'(rsp_tuser), int'(want.err));
            end
         end
         if (req_tvalid && req_tready) decode_char(req_tdata, req_tlast);
      end
      pending    <= expected_bytes.size();
      fail_count <= fault_total;
   end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// regression for the base64 stream decoder: directed messages covering the
// alphabet edges, padding rules and error cases, then random encoded
// messages, some broken on purpose, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam int GAP_MAX        = 8;
   localparam int RANDOM_ITEMS   = 90;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BYTE_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;

   int                   fail_count;
   int                   pending;
   int                   req_gap_max   = GAP_MAX;
   int                   rsp_stall_max = GAP_MAX;
   int                   item_count    = 0;
   int                   idle_cycles   = 0;
   logic [CHAR_W-1:0]    text_q[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   base64_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   b64d_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
      if (v < 6'd26) return CHAR_UA + v;
      else if (v < 6'd52) return CHAR_LA + (v - 6'd26);
      else if (v < 6'd62) return CHAR_D0 + (v - 6'd52);
      else if (v == 6'd62) return CHAR_PLUS;
      else return CHAR_SLASH;
   endfunction

   task automatic load_text(input string s);
      int i;
      text_q.delete();
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // random bytes encoded, unused low bits of a short group sometimes set
   task automatic encode_bytes(input int count);
      logic [23:0]          grp;
      logic [SEXTET_W-1:0]  s1;
      logic [SEXTET_W-1:0]  s2;
      int                   i;
      int                   n;
      text_q.delete();
      for (i = 0; i < count; i += 3) begin
         n   = (count - i >= 3) ? 3 : count - i;
         grp = 24'($urandom);
         if (n < 3) grp[7:0] = '0;
         if (n < 2) grp[15:8] = '0;
         s1 = grp[17:12];
         s2 = grp[11:6];
         if ($urandom_range(0, 1) == 1) begin
            if (n == 1) s1[3:0] = 4'($urandom);
            if (n == 2) s2[1:0] = 2'($urandom);
         end
         text_q.push_back(sextet_char(grp[23:18]));
         text_q.push_back(sextet_char(s1));
         text_q.push_back((n >= 2) ? sextet_char(s2) : CHAR_PAD);
         text_q.push_back((n == 3) ? sextet_char(grp[5:0]) : CHAR_PAD);
      end
   endtask

   task automatic send_text();
      int gap;
      int i;
      for (i = 0; i < text_q.size(); i++) begin
         gap = $urandom_range(0, req_gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= text_q[i];
         req_tlast  <= (i == text_q.size() - 1);
         do @(posedge clock); while (!req_tready);
         item_count++;
         @(negedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int first_random;
      int msg_count;
      int kind;
      int idx;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      load_text("////");
      send_text();
      load_text("AB==");
      send_text();
      load_text("z=9a");
      send_text();
      load_text("+/=A");
      send_text();
      load_text("TQ==a");
      send_text();
      load_text("TWFu");
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      send_text();
      hold_until_drained();

      first_random = item_count;
      msg_count    = 0;
      while (item_count - first_random < RANDOM_ITEMS) begin
         if (msg_count % 8 == 0) hold_until_drained();
         if ($urandom_range(0, 4) == 0) begin
            req_gap_max   = 0;
            rsp_stall_max = 0;
         end else begin
            req_gap_max   = GAP_MAX;
            rsp_stall_max = GAP_MAX;
         end
         kind = $urandom_range(0, 9);
         if (kind < 9) begin
            encode_bytes($urandom_range(1, 7));
            if (kind >= 7) begin
               idx = $urandom_range(0, text_q.size() - 1);
               case ($urandom_range(0, 3))
                  0:       text_q[idx] = CHAR_W'($urandom_range(0, 255));
                  1:       text_q.delete(text_q.size() - 1);
                  2:       text_q[idx] = CHAR_PAD;
                  default: text_q.push_back(sextet_char(SEXTET_W'($urandom_range(0, 63))));
               endcase
            end
         end else begin
            text_q.delete();
            repeat ($urandom_range(1, 8)) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
         end
         send_text();
         msg_count++;
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("base64_stream_decoder regression: pass");
      end else begin
         $display("base64_stream_decoder regression: fail");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("base64_stream_decoder regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* filelist.f */
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_stream_decoder.sv
test/b64d_checker.sv
test/tb_top.sv
